// File: hw/rtl/lor_pkg.sv
// Package for the largest-ones-rectangle block: sizes, widths, shared types.
// No dependencies.
`default_nettype none
package lor_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int CfgW    = 7;
  localparam int ColW    = $clog2(MaxCols);
  localparam int RowW    = $clog2(MaxRows);
  localparam int HgtW    = $clog2(MaxRows + 1);
  localparam int DepW    = $clog2(MaxCols + 1);
  localparam int AreaW   = 13;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegNumRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegNumCols = 1'b1;

  // One queued cell, tagged with its position.
  typedef struct packed {
    logic            black;
    logic [ColW-1:0] col;
    logic            row_end;
    logic            mat_end;
  } cell_t;
endpackage
`default_nettype wire

// File: hw/rtl/lor_if.sv
// Valid/ready channel interfaces for cells, results and register writes.
// Depends on lor_pkg.
`default_nettype none
interface lor_cell_if;
  logic valid;
  logic ready;
  logic cell_req;
  modport source (output valid, output cell_req, input ready);
  modport sink   (input valid, input cell_req, output ready);
endinterface

interface lor_area_if;
  logic valid;
  logic ready;
  logic [lor_pkg::AreaW-1:0] best_area;
  modport source (output valid, output best_area, input ready);
  modport sink   (input valid, input best_area, output ready);
endinterface

interface lor_cfg_if;
  logic valid;
  logic ready;
  logic [lor_pkg::CfgIdxW-1:0] index;
  logic [lor_pkg::CfgW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lor_front.sv
// Front end: accepts cells, tracks row/column position, tags row/matrix ends.
// Depends on lor_pkg.
`default_nettype none
module lor_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        cell_i,
  input  wire [lor_pkg::CfgW-1:0]    num_rows_i,
  input  wire [lor_pkg::CfgW-1:0]    num_cols_i,
  output logic                       push_o,
  output lor_pkg::cell_t             push_data_o,
  input  wire                        full_i
);
  logic [lor_pkg::RowW-1:0] row_q, row_d;
  logic [lor_pkg::ColW-1:0] col_q, col_d;
  logic [lor_pkg::CfgW-1:0] rows_eff, cols_eff;
  logic row_end, mat_end;

  always_comb begin
    rows_eff = (num_rows_i == '0) ? lor_pkg::CfgW'(1) :
               (num_rows_i > lor_pkg::CfgW'(lor_pkg::MaxRows)) ?
               lor_pkg::CfgW'(lor_pkg::MaxRows) : num_rows_i;
    cols_eff = (num_cols_i == '0) ? lor_pkg::CfgW'(1) :
               (num_cols_i > lor_pkg::CfgW'(lor_pkg::MaxCols)) ?
               lor_pkg::CfgW'(lor_pkg::MaxCols) : num_cols_i;
    row_end  = (lor_pkg::CfgW'(col_q) + 1'b1) >= cols_eff;
    mat_end  = row_end && ((lor_pkg::CfgW'(row_q) + 1'b1) >= rows_eff);
    in_ready_o = !full_i;
    push_o = in_valid_i && !full_i;
    push_data_o.black   = cell_i;
    push_data_o.col     = col_q;
    push_data_o.row_end = row_end;
    push_data_o.mat_end = mat_end;
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = mat_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lor_fifo.sv
// Short queue between front and back ends.
// Depends on lor_pkg.
`default_nettype none
module lor_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  lor_pkg::cell_t  push_data_i,
  output logic            full_o,
  input  wire             pop_i,
  output lor_pkg::cell_t  pop_data_o,
  output logic            empty_o
);
  lor_pkg::cell_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o     = cnt_q == 3'd4;
  assign empty_o    = cnt_q == 3'd0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("fifo overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("fifo underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("fifo count out of range");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/lor_back.sv
// Back end: histogram update, monotone stack with pops, row flush, best area.
// Depends on lor_pkg.
`default_nettype none
module lor_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         empty_i,
  input  lor_pkg::cell_t              item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [lor_pkg::AreaW-1:0]   best_area_o
);
  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_MUL   = 5'b00100,
    S_FLUSH = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  // stack entry: column and its height (fixed while the row is open)
  typedef struct packed {
    logic [lor_pkg::ColW-1:0] col;
    logic [lor_pkg::HgtW-1:0] hgt;
  } bar_t;

  state_e state_q, state_d;
  // heights: valid bits emulate reset-to-zero
  logic [lor_pkg::HgtW-1:0] hgt_q [lor_pkg::MaxCols];
  logic [lor_pkg::MaxCols-1:0] hv_q;
  bar_t stk_q [lor_pkg::MaxCols];
  // top entry and the one below it, kept in registers
  bar_t top_q, below_q;
  bar_t push_bar;
  logic [lor_pkg::DepW-1:0] dep_q;
  logic [lor_pkg::AreaW-1:0] best_q;
  lor_pkg::cell_t cur_q;
  logic [lor_pkg::HgtW-1:0] hrd_q;
  logic hvld_q;
  logic [lor_pkg::HgtW-1:0] ph_q;
  logic [lor_pkg::DepW-1:0] wid_q;
  logic [lor_pkg::AreaW-1:0] area_d;
  logic [lor_pkg::HgtW-1:0] cur_h;
  logic [lor_pkg::DepW-1:0] endp, left;
  logic [lor_pkg::DepW-1:0] dm1, dm2;
  logic do_pop, flushing_q;

  always_comb begin
    dm1       = dep_q - 1'b1;
    dm2       = dep_q - 2'd2;
    cur_h     = !cur_q.black ? '0 :
                hvld_q ? hrd_q + 1'b1 : lor_pkg::HgtW'(1);
    push_bar.col = cur_q.col;
    push_bar.hgt = cur_h;
    endp      = flushing_q ? lor_pkg::DepW'(cur_q.col) + 1'b1
                           : lor_pkg::DepW'(cur_q.col);
    left      = (dep_q > lor_pkg::DepW'(1)) ?
                lor_pkg::DepW'(below_q.col) + 1'b1 : '0;
    do_pop    = (dep_q != '0) && (flushing_q || top_q.hgt >= cur_h);
    area_d    = lor_pkg::AreaW'(ph_q) * lor_pkg::AreaW'(wid_q);
  end

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    unique case (state_q)
      S_LOAD: if (!empty_i) begin
        pop_o = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (do_pop) state_d = S_MUL;
        else if (!flushing_q && cur_q.row_end) state_d = S_FLUSH;
        else if (flushing_q && cur_q.mat_end) state_d = S_OUT;
        else state_d = S_LOAD;
      end
      S_MUL:   state_d = S_SCAN;
      S_FLUSH: state_d = S_SCAN;
      S_OUT:   if (out_ready_i) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  assign out_valid_o = state_q == S_OUT;
  assign best_area_o = best_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && !empty_i) begin
      cur_q  <= item_i;
      hrd_q  <= hgt_q[item_i.col];
      hvld_q <= hv_q[item_i.col];
    end
    if (state_q == S_SCAN && !flushing_q) begin
      hgt_q[cur_q.col] <= cur_h;
    end
    if (state_q == S_SCAN && do_pop) begin
      ph_q  <= top_q.hgt;
      wid_q <= endp - left;
      top_q <= below_q;
    end
    if (state_q == S_SCAN && !do_pop && !flushing_q) begin
      stk_q[dep_q[lor_pkg::ColW-1:0]] <= push_bar;
      top_q   <= push_bar;
      below_q <= top_q;
    end
    // refill the entry under the new top after a pop
    if (state_q == S_MUL) begin
      below_q <= stk_q[dm2[lor_pkg::ColW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      hv_q <= '0;
      dep_q <= '0;
      best_q <= '0;
      flushing_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD && !empty_i) begin
        hv_q[item_i.col] <= 1'b1;
        flushing_q <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        if (do_pop) dep_q <= dm1;
        else if (!flushing_q) dep_q <= dep_q + 1'b1;
      end
      if (state_q == S_MUL && area_d > best_q) best_q <= area_d;
      if (state_q == S_FLUSH) flushing_q <= 1'b1;
      if (state_q == S_OUT && out_ready_i) begin
        hv_q <= '0;
        best_q <= '0;
        dep_q <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dep_q == '0) else $error("stack not empty at result");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= lor_pkg::DepW'(lor_pkg::MaxCols)) else $error("stack overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(best_area_o))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/largest_ones_rectangle.sv
// Largest all-black rectangle in a streamed binary matrix.
// Result: once the final cell is taken, the area is valid after the back end loads it,
// pops the bars for that cell and in the row flush, and reaches its output state.
// Back end: works on one cell at a time (load, scan, a multiply step per stack pop,
// a flush step per row end); each column is pushed and popped once a row.
// Reset (rst_ni low, async): heights, stack, best area, position cleared;
// sizes return to 64x64. The front takes cells while the 4-entry queue has room.
`default_nettype none
module largest_ones_rectangle (
  input  wire        clk_i,
  input  wire        rst_ni,
  lor_cell_if.sink   cell_in,
  lor_area_if.source area_out,
  lor_cfg_if.sink    cfg_in
);
  logic [lor_pkg::CfgW-1:0] rows_q, cols_q;
  logic push, full, empty, pop;
  lor_pkg::cell_t push_data, pop_data;

  // Register writes are always taken.
  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lor_pkg::CfgW'(lor_pkg::MaxRows);
      cols_q <= lor_pkg::CfgW'(lor_pkg::MaxCols);
    end else if (cfg_in.valid) begin
      unique case (cfg_in.index)
        lor_pkg::RegNumRows: rows_q <= cfg_in.data;
        lor_pkg::RegNumCols: cols_q <= cfg_in.data;
        default: ;
      endcase
    end
  end

  lor_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (cell_in.valid),
    .in_ready_o (cell_in.ready),
    .cell_i     (cell_in.cell_req),
    .num_rows_i (rows_q),
    .num_cols_i (cols_q),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  lor_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  lor_back u_back (
    .clk_i, .rst_ni,
    .empty_i    (empty),
    .item_i     (pop_data),
    .pop_o      (pop),
    .out_valid_o(area_out.valid),
    .out_ready_i(area_out.ready),
    .best_area_o(area_out.best_area)
  );
endmodule
`default_nettype wire
